// ===== rtl/core/wavhp_pkg.sv =====
`default_nettype none
package wavhp_pkg;

	localparam logic [31:0] TAG_RIFF     = 32'h5249_4646;
	localparam logic [31:0] TAG_WAVE     = 32'h5741_5645;
	localparam logic [31:0] TAG_FMT      = 32'h666D_7420;
	localparam logic [31:0] TAG_DATA     = 32'h6461_7461;
	localparam logic [31:0] FMT_BODY_LEN = 32'd16;
	localparam logic [15:0] BITS_UINT    = 16'd8;
	localparam logic [15:0] BITS_FLOAT   = 16'd32;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_BAD_RIFF   = 3'd1,
		ST_NO_FMT     = 3'd2,
		ST_NO_DATA    = 3'd3,
		ST_ZERO_FRAME = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		KIND_UINT  = 2'd0,
		KIND_SINT  = 2'd1,
		KIND_FLOAT = 2'd2
	} kind_t;

	// controller -> datapath
	typedef struct packed {
		logic    step;
		logic    hdr_byte;
		logic    held_byte;
		logic    idx_inc;
		logic    idx_clr;
		logic    skip_load_len;
		logic    skip_load_extra;
		logic    skip_dec;
		logic    res_load;
		logic    res_fill;
		logic    res_fire;
		status_t res_status;
		logic    div_start;
	} wavhp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic i_eq3;
		logic i_eq7;
		logic i_eq11;
		logic i_eq15;
		logic riff_ok;
		logic wave_ok;
		logic fmt_tag;
		logic data_tag;
		logic len_zero;
		logic len_ge16;
		logic len_gt16;
		logic skip_one;
		logic bpf_zero;
		logic div_done;
		logic out_busy;
	} wavhp_flag_t;

endpackage
`default_nettype wire

// ===== rtl/core/wavhp_div.sv =====
`default_nettype none
module wavhp_div
	import wavhp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] dividend,
	input  wire logic [31:0] divisor,
	output logic             done,
	output logic [31:0]      quotient
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] dsr_q;
	logic [32:0] rem_sh;
	logic [32:0] diff;
	logic        ge;

	// restoring division, one quotient bit per cycle
	assign rem_sh = {rem_q, quo_q[31]};
	assign diff   = rem_sh - {1'b0, dsr_q};
	assign ge     = rem_sh >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 5'd31);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[31:0] : rem_sh[31:0];
			quo_q <= {quo_q[30:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

// ===== rtl/core/wavhp_dp.sv =====
`default_nettype none
module wavhp_dp
	import wavhp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [7:0]  data_byte,
	input  wire logic        restart,
	input  wire wavhp_cmd_t  cmd,
	input  wire logic        out_take,
	output wavhp_flag_t      flg,
	output logic             out_valid,
	output logic [2:0]       status,
	output logic [31:0]      sample_rate,
	output logic [15:0]      channel_count,
	output logic [15:0]      sample_bits,
	output logic [1:0]       sample_kind,
	output logic [31:0]      data_offset,
	output logic [31:0]      frame_count
);

	logic [3:0]  idx_q;
	logic [31:0] tag_q;
	logic [31:0] len_q;
	logic [31:0] skip_q;
	logic [15:0] ch_q;
	logic [31:0] rate_q;
	logic [15:0] bits_q;
	logic [31:0] pos_q;
	logic [28:0] bpf_q;
	logic        out_valid_q;
	logic [2:0]  status_q;
	logic [31:0] rate_out_q;
	logic [15:0] ch_out_q;
	logic [15:0] bits_out_q;
	logic [1:0]  kind_q;
	logic [31:0] offset_q;
	logic [31:0] frames_q;

	logic [3:0]  eff_idx;
	logic [31:0] new_pos;
	logic [31:0] full_len;
	logic [31:0] shift_tag;
	logic [1:0]  kind;
	logic        div_done;
	logic [31:0] quotient;

	// a first byte restarts the index and position for this very byte
	assign eff_idx   = restart ? 4'd0 : idx_q;
	assign new_pos   = (restart ? 32'd0 : pos_q) + 32'd1;
	assign full_len  = {data_byte, len_q[23:0]};
	assign shift_tag = {tag_q[23:0], data_byte};

	always_comb begin
		if (bits_q == BITS_UINT)
			kind = KIND_UINT;
		else if (bits_q == BITS_FLOAT)
			kind = KIND_FLOAT;
		else
			kind = KIND_SINT;
	end

	always_comb begin
		flg.i_eq3    = eff_idx == 4'd3;
		flg.i_eq7    = eff_idx == 4'd7;
		flg.i_eq11   = eff_idx == 4'd11;
		flg.i_eq15   = eff_idx == 4'd15;
		flg.riff_ok  = shift_tag == TAG_RIFF;
		flg.wave_ok  = shift_tag == TAG_WAVE;
		flg.fmt_tag  = tag_q == TAG_FMT;
		flg.data_tag = tag_q == TAG_DATA;
		flg.len_zero = full_len == 32'd0;
		flg.len_ge16 = full_len >= FMT_BODY_LEN;
		flg.len_gt16 = len_q > FMT_BODY_LEN;
		flg.skip_one = skip_q == 32'd1;
		flg.bpf_zero = bpf_q == 29'd0;
		flg.div_done = div_done;
		flg.out_busy = out_valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			tag_q  <= '0;
			len_q  <= '0;
			skip_q <= '0;
			ch_q   <= '0;
			rate_q <= '0;
			bits_q <= '0;
			pos_q  <= '0;
			bpf_q  <= '0;
		end else begin
			// bytes per frame, settled long before a data header completes
			bpf_q <= {16'd0, bits_q[15:3]} * {13'd0, ch_q};
			if (cmd.step)
				pos_q <= new_pos;
			if (cmd.idx_clr)
				idx_q <= '0;
			else if (cmd.idx_inc)
				idx_q <= eff_idx + 4'd1;
			// tag bytes in index 0-3 and 8-11, length bytes in 4-7
			if (cmd.hdr_byte) begin
				if (!eff_idx[2]) begin
					tag_q <= shift_tag;
				end else begin
					case (eff_idx[1:0])
						2'd0:    len_q[7:0]   <= data_byte;
						2'd1:    len_q[15:8]  <= data_byte;
						2'd2:    len_q[23:16] <= data_byte;
						default: len_q[31:24] <= data_byte;
					endcase
				end
			end
			if (cmd.held_byte) begin
				case (eff_idx)
					4'd2:    ch_q[7:0]     <= data_byte;
					4'd3:    ch_q[15:8]    <= data_byte;
					4'd4:    rate_q[7:0]   <= data_byte;
					4'd5:    rate_q[15:8]  <= data_byte;
					4'd6:    rate_q[23:16] <= data_byte;
					4'd7:    rate_q[31:24] <= data_byte;
					4'd14:   bits_q[7:0]   <= data_byte;
					4'd15:   bits_q[15:8]  <= data_byte;
					default: ;
				endcase
			end
			if (cmd.skip_load_len)
				skip_q <= full_len;
			else if (cmd.skip_load_extra)
				skip_q <= len_q - FMT_BODY_LEN;
			else if (cmd.skip_dec)
				skip_q <= skip_q - 32'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.res_fire || div_done)
			out_valid_q <= 1'b1;
		else if (out_take)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			status_q <= cmd.res_status;
			frames_q <= '0;
			if (cmd.res_fill) begin
				rate_out_q <= rate_q;
				ch_out_q   <= ch_q;
				bits_out_q <= bits_q;
				kind_q     <= kind;
				offset_q   <= new_pos;
			end else begin
				rate_out_q <= '0;
				ch_out_q   <= '0;
				bits_out_q <= '0;
				kind_q     <= '0;
				offset_q   <= '0;
			end
		end else if (div_done) begin
			frames_q <= quotient;
		end
	end

	wavhp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (full_len),
		.divisor  ({3'b000, bpf_q}),
		.done     (div_done),
		.quotient (quotient)
	);

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign sample_rate   = rate_out_q;
	assign channel_count = ch_out_q;
	assign sample_bits   = bits_out_q;
	assign sample_kind   = kind_q;
	assign data_offset   = offset_q;
	assign frame_count   = frames_q;

endmodule
`default_nettype wire

// ===== rtl/core/wavhp_ctrl.sv =====
`default_nettype none
module wavhp_ctrl
	import wavhp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_acc,
	input  wire logic        first,
	input  wire logic        last,
	input  wire wavhp_flag_t flg,
	output wavhp_cmd_t       cmd,
	output logic             in_ready
);

	typedef enum logic [8:0] {
		PH_RIFF      = 9'b0_0000_0001,
		PH_FMT_HDR   = 9'b0_0000_0010,
		PH_FMT_BODY  = 9'b0_0000_0100,
		PH_FMT_EXTRA = 9'b0_0000_1000,
		PH_FMT_SKIP  = 9'b0_0001_0000,
		PH_DATA_HDR  = 9'b0_0010_0000,
		PH_DATA_SKIP = 9'b0_0100_0000,
		PH_DIV       = 9'b0_1000_0000,
		PH_DONE      = 9'b1_0000_0000
	} phase_t;

	phase_t  phase_q;
	phase_t  phase_eff;
	phase_t  phase_nxt;
	logic    result;
	logic    go_div;
	status_t code;

	assign in_ready  = !flg.out_busy && (phase_q != PH_DIV);
	assign phase_eff = first ? PH_RIFF : phase_q;

	always_comb begin
		cmd       = '0;
		phase_nxt = phase_q;
		result    = 1'b0;
		go_div    = 1'b0;
		code      = ST_OK;
		if (in_acc && (phase_eff != PH_DONE)) begin
			cmd.step  = 1'b1;
			phase_nxt = phase_eff;
			unique case (phase_eff)
				PH_RIFF: begin
					cmd.hdr_byte = 1'b1;
					cmd.idx_inc  = !flg.i_eq11;
					if ((flg.i_eq3 && !flg.riff_ok) || (flg.i_eq7 && flg.len_zero) ||
							(flg.i_eq11 && !flg.wave_ok)) begin
						result = 1'b1;
						code   = ST_BAD_RIFF;
					end else if (flg.i_eq11) begin
						cmd.idx_clr = 1'b1;
						phase_nxt   = PH_FMT_HDR;
					end
				end
				PH_FMT_HDR: begin
					cmd.hdr_byte = 1'b1;
					cmd.idx_inc  = 1'b1;
					if (flg.i_eq7) begin
						if (flg.fmt_tag && flg.len_ge16) begin
							cmd.idx_clr = 1'b1;
							phase_nxt   = PH_FMT_BODY;
						end else if (flg.len_zero) begin
							result = 1'b1;
							code   = ST_NO_FMT;
						end else begin
							cmd.skip_load_len = 1'b1;
							phase_nxt         = PH_FMT_SKIP;
						end
					end
				end
				PH_FMT_BODY: begin
					cmd.held_byte = 1'b1;
					if (!flg.i_eq15) begin
						cmd.idx_inc = 1'b1;
					end else if (flg.len_gt16) begin
						cmd.skip_load_extra = 1'b1;
						phase_nxt           = PH_FMT_EXTRA;
					end else begin
						cmd.idx_clr = 1'b1;
						phase_nxt   = PH_DATA_HDR;
					end
				end
				PH_FMT_EXTRA, PH_FMT_SKIP, PH_DATA_SKIP: begin
					cmd.skip_dec = 1'b1;
					if (flg.skip_one) begin
						cmd.idx_clr = 1'b1;
						phase_nxt   = (phase_eff == PH_FMT_SKIP) ? PH_FMT_HDR : PH_DATA_HDR;
					end
				end
				PH_DATA_HDR: begin
					cmd.hdr_byte = 1'b1;
					cmd.idx_inc  = 1'b1;
					if (flg.i_eq7) begin
						if (flg.data_tag && !flg.len_zero) begin
							result = 1'b1;
							if (flg.bpf_zero) begin
								code = ST_ZERO_FRAME;
							end else begin
								code   = ST_OK;
								go_div = 1'b1;
							end
						end else if (flg.len_zero) begin
							result = 1'b1;
							code   = ST_NO_DATA;
						end else begin
							cmd.skip_load_len = 1'b1;
							phase_nxt         = PH_DATA_SKIP;
						end
					end
				end
				default: ;
			endcase
			// stream ends without a verdict: report by where the scan stopped
			if (!result && last) begin
				result = 1'b1;
				if (phase_nxt == PH_RIFF)
					code = ST_BAD_RIFF;
				else if ((phase_nxt == PH_DATA_HDR) || (phase_nxt == PH_DATA_SKIP))
					code = ST_NO_DATA;
				else
					code = ST_NO_FMT;
			end
			if (result) begin
				cmd.res_load   = 1'b1;
				cmd.res_status = code;
				cmd.res_fill   = (code == ST_OK) || (code == ST_ZERO_FRAME);
				cmd.res_fire   = !go_div;
				cmd.div_start  = go_div;
				phase_nxt      = go_div ? PH_DIV : PH_DONE;
			end
		end else if ((phase_q == PH_DIV) && flg.div_done) begin
			phase_nxt = PH_DONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			phase_q <= PH_RIFF;
		else
			phase_q <= phase_nxt;
	end

endmodule
`default_nettype wire

// ===== rtl/core/wav_header_chunk_parser.sv =====
// Timing: a result sits in its output register the cycle after the deciding byte,
//   or once the divider is done if a frame count is divided out (status ok).
// Throughput: one byte per cycle; input stalls while a result waits to be taken
//   and while the bit-serial divider runs, once per file.
// Reset (arst_n low, asynchronous): parser at the RIFF header, counters cleared,
//   output transaction invalid.
`default_nettype none
module wav_header_chunk_parser
	import wavhp_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	// input byte stream
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [7:0]   s_axis_tdata,  // [7:0] data_byte
	input  wire logic         s_axis_tuser,  // [0] first_byte
	input  wire logic         s_axis_tlast,  // last_byte
	// one result transaction per file
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// [2:0] status, [34:3] sample_rate, [50:35] channel_count,
	// [66:51] sample_bits, [68:67] sample_kind, [100:69] data_offset,
	// [132:101] frame_count, [135:133] zero
	output logic [135:0]      m_axis_tdata
);

	wavhp_cmd_t  cmd;
	wavhp_flag_t flg;
	logic        in_acc;
	logic        restart;
	logic [2:0]  status;
	logic [31:0] sample_rate;
	logic [15:0] channel_count;
	logic [15:0] sample_bits;
	logic [1:0]  sample_kind;
	logic [31:0] data_offset;
	logic [31:0] frame_count;

	assign in_acc  = s_axis_tvalid && s_axis_tready;
	// a marked first byte restarts parsing with that byte itself
	assign restart = in_acc && s_axis_tuser;

	// phase sequencing: header, fmt search/body, data search, divide wait
	wavhp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_acc   (in_acc),
		.first    (s_axis_tuser),
		.last     (s_axis_tlast),
		.flg      (flg),
		.cmd      (cmd),
		.in_ready (s_axis_tready)
	);

	// tag/length capture, fmt fields, skip counter, position, divider, result reg
	wavhp_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.data_byte     (s_axis_tdata),
		.restart       (restart),
		.cmd           (cmd),
		.out_take      (m_axis_tready),
		.flg           (flg),
		.out_valid     (m_axis_tvalid),
		.status        (status),
		.sample_rate   (sample_rate),
		.channel_count (channel_count),
		.sample_bits   (sample_bits),
		.sample_kind   (sample_kind),
		.data_offset   (data_offset),
		.frame_count   (frame_count)
	);

	assign m_axis_tdata = {3'b000, frame_count, data_offset, sample_kind,
		sample_bits, channel_count, sample_rate, status};

endmodule
`default_nettype wire

// ===== tb/wav_header_checker.sv =====
`timescale 1ns / 100ps
module wav_header_checker
	import wavhp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,  // [7:0] data_byte
	input  logic         s_axis_tuser,  // [0] first_byte
	input  logic         s_axis_tlast,  // last_byte
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [2:0] status, [34:3] sample_rate, [50:35] channel_count,
	// [66:51] sample_bits, [68:67] sample_kind, [100:69] data_offset,
	// [132:101] frame_count, [135:133] zero
	input  logic [135:0] m_axis_tdata,
	output int unsigned  fail_count,
	output int unsigned  pending
);

	typedef enum logic [2:0] {
		SCAN_RIFF,
		SCAN_FMT_HDR,
		SCAN_FMT_BODY,
		SCAN_FMT_EXTRA,
		SCAN_FMT_SKIP,
		SCAN_DATA_HDR,
		SCAN_DATA_SKIP
	} scan_phase_t;

	typedef struct {
		status_t     status;
		logic [31:0] rate;
		logic [15:0] chans;
		logic [15:0] bits;
		kind_t       kind;
		logic [31:0] offset;
		logic [31:0] frames;
	} wav_info_t;

	scan_phase_t phase;
	logic [4:0]  idx;
	logic [31:0] skip_left;
	logic [31:0] chunk_len;
	logic [31:0] tag;
	logic [15:0] chans;
	logic [31:0] rate;
	logic [15:0] bits;
	logic [31:0] byte_pos;
	logic        done;

	wav_info_t   info_q[$];
	int unsigned results_seen;

	initial begin
		fail_count = 0;
		pending = 0;
		results_seen = 0;
	end

	task automatic start_header(input scan_phase_t next);
		phase = next;
		idx = '0;
		tag = '0;
		chunk_len = '0;
	endtask

	task automatic restart();
		start_header(SCAN_RIFF);
		skip_left = '0;
		chans = '0;
		rate = '0;
		bits = '0;
		byte_pos = '0;
		done = 1'b0;
	endtask

	// tag bytes first (big-endian), then little-endian length
	task automatic header_byte(input logic [7:0] b, output bit complete);
		int i;
		i = int'(idx[2:0]);
		if (i < 4)
			tag = {tag[23:0], b};
		else
			chunk_len |= 32'(b) << (8 * (i - 4));
		idx = 5'(i + 1);
		complete = (i == 7);
	endtask

	task automatic parse_byte(input logic [7:0] b, input logic first, input logic last,
	                          output bit got, output wav_info_t info);
		int          i;
		bit          complete;
		bit          decided;
		status_t     st;
		logic [31:0] bpf;
		logic [31:0] frames;
		got = 1'b0;
		decided = 1'b0;
		st = ST_OK;
		frames = '0;
		info.status = ST_OK;
		info.rate = '0;
		info.chans = '0;
		info.bits = '0;
		info.kind = KIND_UINT;
		info.offset = '0;
		info.frames = '0;

		if (first)
			restart();
		if (done)
			return;
		byte_pos += 32'd1;

		case (phase)
		SCAN_RIFF: begin
			i = int'(idx[3:0]);
			if (i < 4) begin
				tag = {tag[23:0], b};
				if (i == 3) begin
					if (tag != TAG_RIFF) begin
						decided = 1'b1;
						st = ST_BAD_RIFF;
					end
					tag = '0;
				end
				idx = 5'(i + 1);
			end else if (i < 8) begin
				chunk_len |= 32'(b) << (8 * (i - 4));
				if (i == 7 && chunk_len == 0) begin
					decided = 1'b1;
					st = ST_BAD_RIFF;
				end
				idx = 5'(i + 1);
			end else begin
				tag = {tag[23:0], b};
				if (i == 11) begin
					if (tag != TAG_WAVE) begin
						decided = 1'b1;
						st = ST_BAD_RIFF;
					end else begin
						start_header(SCAN_FMT_HDR);
					end
				end else begin
					idx = 5'(i + 1);
				end
			end
		end
		SCAN_FMT_HDR: begin
			header_byte(b, complete);
			if (complete) begin
				if (tag == TAG_FMT && chunk_len >= FMT_BODY_LEN) begin
					phase = SCAN_FMT_BODY;
					idx = '0;
					chans = '0;
					rate = '0;
					bits = '0;
				end else if (chunk_len == 0) begin
					decided = 1'b1;
					st = ST_NO_FMT;
				end else begin
					skip_left = chunk_len;
					phase = SCAN_FMT_SKIP;
				end
			end
		end
		SCAN_FMT_BODY: begin
			// body: format code, channels, rate, byte rate, block align, bits
			i = int'(idx[3:0]);
			if (i == 2 || i == 3)
				chans |= 16'(b) << (8 * (i - 2));
			else if (i >= 4 && i <= 7)
				rate |= 32'(b) << (8 * (i - 4));
			else if (i == 14 || i == 15)
				bits |= 16'(b) << (8 * (i - 14));
			if (i == 15) begin
				if (chunk_len > FMT_BODY_LEN) begin
					skip_left = chunk_len - FMT_BODY_LEN;
					phase = SCAN_FMT_EXTRA;
				end else begin
					start_header(SCAN_DATA_HDR);
				end
			end else begin
				idx = 5'(i + 1);
			end
		end
		SCAN_FMT_EXTRA, SCAN_FMT_SKIP, SCAN_DATA_SKIP: begin
			skip_left -= 32'd1;
			if (skip_left == 0) begin
				if (phase == SCAN_FMT_SKIP)
					start_header(SCAN_FMT_HDR);
				else
					start_header(SCAN_DATA_HDR);
			end
		end
		SCAN_DATA_HDR: begin
			header_byte(b, complete);
			if (complete) begin
				if (tag == TAG_DATA && chunk_len != 0) begin
					bpf = 32'(bits >> 3) * 32'(chans);
					decided = 1'b1;
					if (bpf == 0) begin
						st = ST_ZERO_FRAME;
					end else begin
						st = ST_OK;
						frames = chunk_len / bpf;
					end
				end else if (chunk_len == 0) begin
					decided = 1'b1;
					st = ST_NO_DATA;
				end else begin
					skip_left = chunk_len;
					phase = SCAN_DATA_SKIP;
				end
			end
		end
		default: begin
			decided = 1'b1;
			st = ST_NO_DATA;
		end
		endcase

		// stream ended before the outcome was known
		if (!decided && last) begin
			decided = 1'b1;
			if (phase == SCAN_RIFF)
				st = ST_BAD_RIFF;
			else if (phase <= SCAN_FMT_SKIP)
				st = ST_NO_FMT;
			else
				st = ST_NO_DATA;
		end
		if (!decided)
			return;

		done = 1'b1;
		got = 1'b1;
		info.status = st;
		if (st == ST_OK || st == ST_ZERO_FRAME) begin
			info.rate = rate;
			info.chans = chans;
			info.bits = bits;
			if (bits == BITS_UINT)
				info.kind = KIND_UINT;
			else if (bits == BITS_FLOAT)
				info.kind = KIND_FLOAT;
			else
				info.kind = KIND_SINT;
			info.offset = byte_pos;
			info.frames = frames;
		end
	endtask

	task automatic report_mismatch(input string msg);
		$display("%0t: mismatch: %s", $time, msg);
		fail_count++;
	endtask

	task automatic compare_field(input string name, input logic [31:0] seen,
	                             input logic [31:0] want);
		if (seen !== want)
			report_mismatch($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
			                          results_seen, name, seen, want));
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		wav_info_t want;
		wav_info_t made;
		bit        got;
		if (!arst_n) begin
			restart();
			info_q.delete();
		end else begin
			// output first: a result leaving now belongs to an earlier byte
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen++;
				if (info_q.size() == 0) begin
					report_mismatch($sformatf("result %0d arrived with none expected",
					                          results_seen));
				end else begin
					want = info_q.pop_front();
					compare_field("status", m_axis_tdata[2:0], want.status);
					compare_field("sample_rate", m_axis_tdata[34:3], want.rate);
					compare_field("channel_count", m_axis_tdata[50:35], want.chans);
					compare_field("sample_bits", m_axis_tdata[66:51], want.bits);
					compare_field("sample_kind", m_axis_tdata[68:67], want.kind);
					compare_field("data_offset", m_axis_tdata[100:69], want.offset);
					compare_field("frame_count", m_axis_tdata[132:101], want.frames);
					compare_field("pad", m_axis_tdata[135:133], '0);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				parse_byte(s_axis_tdata, s_axis_tuser, s_axis_tlast, got, made);
				if (got)
					info_q.push_back(made);
			end
		end
		pending = info_q.size();
	end

endmodule

// ===== tb/tb_wav_header_chunk_parser.sv =====
`timescale 1ns / 100ps
module tb_wav_header_chunk_parser;
	import wavhp_pkg::*;

	// chunk tag used for filler chunks that the parser has to skip
	localparam logic [31:0] TAG_LIST = 32'h4C49_5354;
	// cycles with no transaction on either side before the run is declared hung;
	// worst legal quiet stretch is the divide plus a short output stall
	localparam int unsigned WATCHDOG_LIMIT = 1000;
	// settle time after the last expected result, for stray results to show
	localparam int unsigned DRAIN_CYCLES = 50;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [7:0]   s_axis_tdata;   // [7:0] data_byte
	logic         s_axis_tuser;   // [0] first_byte
	logic         s_axis_tlast;   // last_byte
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	// [2:0] status, [34:3] sample_rate, [50:35] channel_count,
	// [66:51] sample_bits, [68:67] sample_kind, [100:69] data_offset,
	// [132:101] frame_count, [135:133] zero
	logic [135:0] m_axis_tdata;

	int unsigned  fail_count;
	int unsigned  pending;
	int unsigned  quiet_cycles;
	int unsigned  bytes_sent;
	int unsigned  files_sent;
	logic         steady;         // 1: neither side inserts idle cycles
	logic [7:0]   wav_q[$];       // file image being built

	wav_header_chunk_parser dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	wav_header_checker hdr_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// result side: back-pressure about 29% of the time, except in steady stretches
	always @(posedge clk) begin
		m_axis_tready <= steady || ($urandom_range(99) >= 29);
	end

	// hang detection: counts cycles with no transaction on either channel
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
			$display("Regression FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ---------------------------------------------------------------
	// file image builders: tags go out in reading order, numbers
	// little-endian as in a real RIFF file
	// ---------------------------------------------------------------
	task automatic put16(input logic [15:0] v);
		wav_q.push_back(v[7:0]);
		wav_q.push_back(v[15:8]);
	endtask

	task automatic put32(input logic [31:0] v);
		for (int k = 0; k < 4; k++)
			wav_q.push_back(v[8*k +: 8]);
	endtask

	// chunk header plus body_len random body bytes
	task automatic put_chunk(input logic [31:0] tag, input logic [31:0] len, input int body_len);
		for (int k = 3; k >= 0; k--)
			wav_q.push_back(tag[8*k +: 8]);
		put32(len);
		repeat (body_len) wav_q.push_back(8'($urandom()));
	endtask

	// starts a new image: "RIFF", size, "WAVE"
	task automatic put_riff(input logic [31:0] riff_size);
		wav_q.delete();
		put_chunk(TAG_RIFF, riff_size, 0);
		for (int k = 3; k >= 0; k--)
			wav_q.push_back(TAG_WAVE[8*k +: 8]);
	endtask

	// fmt chunk; format code, byte rate and block align are don't-care to the parser
	task automatic put_fmt(input logic [31:0] rate, input logic [15:0] chans,
	                       input logic [15:0] bits, input int extra);
		put_chunk(TAG_FMT, 32'(16 + extra), 0);
		put16(16'($urandom()));
		put16(chans);
		put32(rate);
		put32($urandom());
		put16(16'($urandom()));
		put16(bits);
		repeat (extra) wav_q.push_back(8'($urandom()));
	endtask

	// filler chunk; a short "fmt " is skipped like any other, a "data" one after fmt is taken as the data chunk
	task automatic put_junk();
		logic [31:0] tag;
		logic [31:0] len;
		case ($urandom_range(5))
		0: tag = TAG_FMT;
		1: tag = TAG_DATA;
		2: tag = TAG_LIST;
		default: tag = $urandom();
		endcase
		len = (tag == TAG_FMT) ? 32'($urandom_range(15, 1)) : 32'($urandom_range(12, 1));
		put_chunk(tag, len, int'(len));
	endtask

	// 16-bit stereo: header at 0..11, fmt header 12..19, fmt body 20..35, data header 36..43
	task automatic build_stereo_wav();
		put_riff(32'd4036);
		put_fmt(32'd22050, 16'd2, 16'd16, 0);
		put_chunk(TAG_DATA, 32'd4000, 0);
	endtask

	task automatic build_random_wav();
		logic [31:0] riff_size;
		logic [31:0] rate;
		logic [31:0] data_len;
		logic [15:0] chans;
		logic [15:0] bits;
		do riff_size = $urandom(); while (riff_size == 0);
		case ($urandom_range(9))
		0, 1, 2, 3: chans = 16'($urandom_range(2, 1));
		4, 5, 6: chans = 16'($urandom_range(8, 1));
		7: chans = 16'($urandom());
		8: chans = '0;
		default: chans = '1;
		endcase
		case ($urandom_range(9))
		0, 1: bits = BITS_UINT;
		2, 3: bits = 16'd16;
		4: bits = 16'd24;
		5, 6: bits = BITS_FLOAT;
		7: bits = 16'($urandom());
		8: bits = 16'($urandom_range(7));
		default: bits = '1;
		endcase
		rate = ($urandom_range(3) == 0) ? $urandom() : 32'd44100;
		case ($urandom_range(5))
		0, 1: data_len = $urandom();
		2: data_len = '1;
		default: data_len = 32'($urandom_range(4096, 1));
		endcase
		put_riff(riff_size);
		repeat ($urandom_range(2)) put_junk();
		put_fmt(rate, chans, bits, $urandom_range(1) ? 0 : $urandom_range(6, 1));
		repeat ($urandom_range(2)) put_junk();
		put_chunk(TAG_DATA, data_len, 0);
	endtask

	// ---------------------------------------------------------------
	// byte channel driver: optional idle cycles, then hold the byte
	// until the parser takes it
	// ---------------------------------------------------------------
	task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
		while (!steady && $urandom_range(99) < 29) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tuser <= first;
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// sends the first n bytes of the image
	task automatic send_prefix(input int n, input bit mark_first, input bit last_at_end);
		for (int k = 0; k < n; k++)
			send_byte(wav_q[k], mark_first && k == 0, last_at_end && k == n - 1);
		bytes_sent += n;
		files_sent++;
	endtask

	initial begin
		int mode;
		int n_send;
		int k;
		bit last_end;

		clk = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		s_axis_tlast = 1'b0;
		m_axis_tready = 1'b0;
		steady = 1'b0;
		quiet_cycles = 0;
		bytes_sent = 0;
		files_sent = 0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed files ----

		// no first_byte mark after reset: still parsed from the top; 8-bit mono
		put_riff(32'd1036);
		put_fmt(32'd8000, 16'd1, BITS_UINT, 0);
		put_chunk(TAG_DATA, 32'd1000, 0);
		send_prefix(wav_q.size(), 0, 0);

		// skipped chunks on both sides of fmt, fmt extra bytes, max data length,
		// last_byte on the deciding byte
		put_riff($urandom() | 32'h1);
		put_chunk(TAG_LIST, 32'd5, 5);
		put_fmt(32'd44100, 16'd2, 16'd16, 2);
		put_chunk(TAG_LIST, 32'd3, 3);
		put_chunk(TAG_DATA, '1, 0);
		send_prefix(wav_q.size(), 1, 1);

		// float, smallest RIFF size
		put_riff(32'd1);
		put_fmt(32'd48000, 16'd1, BITS_FLOAT, 0);
		put_chunk(TAG_DATA, 32'd7, 0);
		send_prefix(wav_q.size(), 1, 0);

		// 24-bit signed, all-ones rate, channels and data length
		put_riff('1);
		put_fmt('1, '1, 16'd24, 0);
		put_chunk(TAG_DATA, '1, 0);
		send_prefix(wav_q.size(), 1, 0);

		// widest sample and channel fields
		put_riff(32'd100);
		put_fmt(32'd96000, '1, '1, 0);
		put_chunk(TAG_DATA, '1, 0);
		send_prefix(wav_q.size(), 1, 0);

		// zero frame size: no channels, then fewer than 8 bits
		put_riff(32'd100);
		put_fmt('0, '0, 16'd16, 0);
		put_chunk(TAG_DATA, 32'd64, 0);
		send_prefix(wav_q.size(), 1, 0);
		put_riff(32'd100);
		put_fmt(32'd11025, 16'd2, 16'd7, 0);
		put_chunk(TAG_DATA, 32'd64, 0);
		send_prefix(wav_q.size(), 1, 0);

		// bad RIFF tag; the bytes after the verdict are ignored
		build_stereo_wav();
		wav_q[3] ^= 8'h80;
		send_prefix(wav_q.size(), 1, 0);

		// zero RIFF size
		put_riff('0);
		put_fmt(32'd8000, 16'd1, BITS_UINT, 0);
		put_chunk(TAG_DATA, 32'd10, 0);
		send_prefix(wav_q.size(), 1, 0);

		// bad WAVE tag
		build_stereo_wav();
		wav_q[11] ^= 8'h01;
		send_prefix(wav_q.size(), 1, 0);

		// zero-length chunk while looking for fmt
		put_riff(32'd100);
		put_chunk(TAG_LIST, '0, 0);
		put_fmt(32'd8000, 16'd1, BITS_UINT, 0);
		put_chunk(TAG_DATA, 32'd10, 0);
		send_prefix(wav_q.size(), 1, 0);

		// fmt chunk one byte short of a full body is skipped, real one follows
		put_riff(32'd100);
		put_chunk(TAG_FMT, 32'd15, 15);
		put_fmt(32'd32000, 16'd3, 16'd16, 0);
		put_chunk(TAG_DATA, 32'd600, 0);
		send_prefix(wav_q.size(), 1, 0);

		// zero-length chunk while looking for data
		put_riff(32'd100);
		put_fmt(32'd8000, 16'd1, BITS_UINT, 0);
		put_chunk(TAG_LIST, '0, 0);
		put_chunk(TAG_DATA, 32'd10, 0);
		send_prefix(wav_q.size(), 1, 0);

		// data chunk of length zero
		put_riff(32'd100);
		put_fmt(32'd8000, 16'd1, BITS_UINT, 0);
		put_chunk(TAG_DATA, '0, 0);
		send_prefix(wav_q.size(), 1, 0);

		// truncation: in the RIFF size, on the WAVE byte, inside the fmt body
		build_stereo_wav();
		send_prefix(6, 1, 1);
		send_prefix(12, 1, 1);
		send_prefix(28, 1, 1);

		// truncation inside the fmt extra bytes
		put_riff(32'd100);
		put_fmt(32'd8000, 16'd1, BITS_UINT, 4);
		put_chunk(TAG_DATA, 32'd10, 0);
		send_prefix(38, 1, 1);

		// truncation while skipping a chunk in the data search
		put_riff(32'd100);
		put_fmt(32'd8000, 16'd1, BITS_UINT, 0);
		put_chunk(TAG_LIST, 32'd10, 10);
		put_chunk(TAG_DATA, 32'd10, 0);
		send_prefix(48, 1, 1);

		// restart in the middle of an unfinished file
		build_stereo_wav();
		send_prefix(20, 1, 0);
		send_prefix(wav_q.size(), 1, 1);

		// one-byte stream marked first and last
		send_byte(8'h52, 1'b1, 1'b1);

		// ---- random files ----
		// mostly well-formed images with random content, the rest damaged
		// images and raw noise; one stretch runs with no idling at all
		while (bytes_sent < 2000 || files_sent < 40) begin
			steady <= (files_sent >= 36 && files_sent < 46);
			mode = $urandom_range(99);
			if (mode < 90) begin
				build_random_wav();
				n_send = wav_q.size();
				last_end = $urandom_range(1);
				if (mode >= 70) begin
					case ($urandom_range(3))
					0: begin
						k = $urandom_range(wav_q.size() - 1);
						wav_q[k] ^= 8'($urandom_range(255, 1));
					end
					1: begin
						n_send = $urandom_range(wav_q.size(), 1);
						last_end = 1'b1;
					end
					2: begin
						for (k = wav_q.size() - 4; k < wav_q.size(); k++)
							wav_q[k] = '0;
					end
					default: begin
						for (k = 4; k < 8; k++)
							wav_q[k] = '0;
					end
					endcase
				end
				send_prefix(n_send, 1, last_end);
				// trailing bytes after the verdict: ignored by the parser
				repeat ($urandom_range(3))
					send_byte(8'($urandom()), 1'b0, $urandom_range(4) == 0);
			end else begin
				n_send = $urandom_range(40, 1);
				for (k = 0; k < n_send; k++)
					send_byte(8'($urandom()), k == 0 || $urandom_range(15) == 0,
					          $urandom_range(19) == 0);
				bytes_sent += n_send;
				files_sent++;
			end
		end

		s_axis_tvalid <= 1'b0;
		steady <= 1'b1;

		// wait for every expected result, then give stray results a chance to show
		do @(negedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
